// ----- design/swm_pkg.sv -----
// Shared types and codes for the stack with median query.
`default_nettype none

package swm_pkg;

	localparam int unsigned SWM_DEPTH = 1024;
	localparam int unsigned VAL_W     = 32;

	// Operation codes.
	localparam logic [1:0] OP_PUSH   = 2'd0;
	localparam logic [1:0] OP_POP    = 2'd1;
	localparam logic [1:0] OP_MEDIAN = 2'd2;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]              operation;
		logic signed [VAL_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic [1:0]              status;
		logic signed [VAL_W-1:0] result_value;
	} result_t;

	// Broadcast to every cell of the sorted row.
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [VAL_W-1:0] key;
	} cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/stack_with_median_query_top.sv -----
// Stack with median query: arrival-order stack in RAM plus a sorted row of cells.
// Pop and median answer via the registered stack RAM read or median read tree, the S_POP or
// S_MED state and the result register; a push passes S_PUSH with no answer. Busy is high
// for the cycle after acceptance, so no new command is taken until idle again. A refused
// push or a pop/median on an empty stack answers in the cycle after acceptance and never raises busy.
// Reset empties the stack at once; stored values are left as they are.
`default_nettype none

module stack_with_median_query_top
	import swm_pkg::*;
#(
	parameter int unsigned DEPTH = SWM_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire item_t item,
	output logic      done,
	output result_t   result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PUSH = 4'b0010,
		S_POP  = 4'b0100,
		S_MED  = 4'b1000
	} state_t;

	state_t                  state_q, state_d;
	logic [CW-1:0]           count_q, count_d;
	logic                    done_q, done_d;
	result_t                 result_q, result_d;
	logic signed [VAL_W-1:0] key_q;
	logic signed [VAL_W-1:0] stack_mem [DEPTH];
	logic signed [VAL_W-1:0] rd_s1;
	logic                    accept;
	logic                    full;
	logic                    empty;
	logic                    push_wr;
	logic [AW-1:0]           top_idx;
	cell_ctl_t               ctl;
	logic signed [VAL_W-1:0] median;

	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_wr = accept && (item.operation == OP_PUSH) && !full;
	assign top_idx = AW'(count_q - CW'(1));

	assign ctl.ins = (state_q == S_PUSH);
	assign ctl.rem = (state_q == S_POP);
	assign ctl.key = (state_q == S_PUSH) ? key_q : rd_s1;

	swm_sorted_row #(
		.DEPTH (DEPTH)
	) u_row (
		.clk    (clk),
		.ctl    (ctl),
		.count  (count_q),
		.median (median)
	);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		done_d   = 1'b0;
		result_d = result_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (item.operation)
						OP_PUSH: begin
							if (full) begin
								done_d   = 1'b1;
								result_d = '{status: ST_FULL, result_value: '0};
							end else begin
								state_d = S_PUSH;
							end
						end
						OP_POP: begin
							if (empty) begin
								done_d   = 1'b1;
								result_d = '{status: ST_EMPTY, result_value: '0};
							end else begin
								state_d = S_POP;
							end
						end
						OP_MEDIAN: begin
							if (empty) begin
								done_d   = 1'b1;
								result_d = '{status: ST_EMPTY, result_value: '0};
							end else begin
								state_d = S_MED;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_PUSH: begin
				count_d = count_q + CW'(1);
				state_d = S_IDLE;
			end
			S_POP: begin
				count_d  = count_q - CW'(1);
				done_d   = 1'b1;
				result_d = '{status: ST_OK, result_value: rd_s1};
				state_d  = S_IDLE;
			end
			S_MED: begin
				done_d   = 1'b1;
				result_d = '{status: ST_OK, result_value: median};
				state_d  = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	// The top of the stack is read every cycle; a pop uses it in the cycle after acceptance.
	always_ff @(posedge clk) begin
		if (push_wr) begin
			stack_mem[AW'(count_q)] <= item.value;
		end
		rd_s1 <= stack_mem[top_idx];
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			key_q <= item.value;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count exceeds depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |=> count_q == $past(count_q) - CW'(1))
		else $error("pop did not remove one element");

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.operation == OP_PUSH && full |=>
			done && result.status == ST_FULL && count_q == $past(count_q))
		else $error("push on full stack not refused");

	a_busy_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUSH |=> !done && state_q == S_IDLE)
		else $error("successful push produced a result");

endmodule

`default_nettype wire

// ----- design/swm_cell.sv -----
// One cell of the sorted row: holds one value and shifts with its neighbors.
`default_nettype none

module swm_cell
	import swm_pkg::*;
(
	input  wire logic                    clk,
	input  wire cell_ctl_t               ctl,
	input  wire logic                    occ,
	input  wire logic signed [VAL_W-1:0] lo_val,
	input  wire logic                    lo_big,
	input  wire logic signed [VAL_W-1:0] hi_val,
	output logic signed [VAL_W-1:0]      val,
	output logic                         big
);

	logic signed [VAL_W-1:0] val_q;
	logic                    gt;
	logic                    ge;

	assign gt  = val_q > ctl.key;
	assign ge  = val_q >= ctl.key;
	// A free slot counts as greater than any key, so an insert lands in it.
	assign big = !occ || gt;
	assign val = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (big) begin
				val_q <= lo_big ? lo_val : ctl.key;
			end
		end else if (ctl.rem) begin
			// The cells at and above the first copy of the key form a suffix.
			if (ge) begin
				val_q <= hi_val;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/swm_sorted_row.sv -----
// Sorted row of cells with a two-level registered tree that reads the median.
`default_nettype none

module swm_sorted_row
	import swm_pkg::*;
#(
	parameter int unsigned DEPTH = SWM_DEPTH
) (
	input  wire logic                         clk,
	input  wire cell_ctl_t                    ctl,
	input  wire logic [$clog2(DEPTH+1)-1:0]   count,
	output logic signed [VAL_W-1:0]           median
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int GW = (AW < 5) ? AW : 5;
	localparam int G  = 1 << GW;
	localparam int NG = (DEPTH + G - 1) / G;
	localparam int HW = (NG > 1) ? $clog2(NG) : 1;
	localparam int IW = $clog2(NG * G);

	logic signed [VAL_W-1:0] val [NG*G];
	logic                    big [DEPTH];
	logic [CW-1:0]           cm1;
	logic [AW-1:0]           mid;
	logic [GW-1:0]           mid_lo;
	logic [HW-1:0]           mid_hi;
	logic signed [VAL_W-1:0] grp_s1 [NG];
	logic [HW-1:0]           hi_s1;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic signed [VAL_W-1:0] lo_v;
		logic                    lo_b;
		logic signed [VAL_W-1:0] hi_v;
		logic signed [VAL_W-1:0] v;
		if (i == 0) begin : g_first
			assign lo_v = '0;
			assign lo_b = 1'b0;
		end else begin : g_mid
			assign lo_v = val[i-1];
			assign lo_b = big[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign hi_v = v;
		end else begin : g_inner
			assign hi_v = val[i+1];
		end
		swm_cell u_cell (
			.clk    (clk),
			.ctl    (ctl),
			.occ    (IDX < count),
			.lo_val (lo_v),
			.lo_big (lo_b),
			.hi_val (hi_v),
			.val    (v),
			.big    (big[i])
		);
		assign val[i] = v;
	end

	for (genvar p = DEPTH; p < NG * G; p++) begin : g_pad
		assign val[p] = '0;
	end

	// Lower median sits at (count - 1) / 2.
	assign cm1    = count - CW'(1);
	assign mid    = AW'(cm1 >> 1);
	assign mid_lo = mid[GW-1:0];
	assign mid_hi = HW'(mid >> GW);

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			grp_s1[g] <= val[IW'(g * G) + IW'(mid_lo)];
		end
		hi_s1 <= mid_hi;
	end

	assign median = grp_s1[hi_s1];

endmodule

`default_nettype wire
